// ===== rtl/htt_pkg.sv =====
// Shared types and constants for the tagged handle table.
// No dependencies; used by every module of the block.
package htt_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TAG_W         = 24;
	localparam int SLOT_W        = 8;
	localparam int HANDLE_W      = TAG_W + SLOT_W;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// occupancy update from the result stage to the slot map
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [SLOT_W-1:0] idx;
	} slot_upd_t;

endpackage

// ===== rtl/htt_tag_mem.sv =====
// Signature tag store: one write port, one read port, registered read data.
// Depends on htt_pkg.
module htt_tag_mem import htt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
	input  logic [TAG_W-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
	output logic [TAG_W-1:0]                          rd_data
);

	logic [TAG_W-1:0] mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/htt_slot_map.sv =====
// Occupancy flags per slot, lowest-free-slot search and flag lookup.
// Depends on htt_pkg.
module htt_slot_map import htt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slot_upd_t         upd,
	input  logic [SLOT_W-1:0] query_idx,
	output logic              query_used,
	output logic              free_found,
	output logic [SLOT_W-1:0] free_idx
);

	localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

	logic [NUM_SLOTS-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (upd.set) begin
			used_q[upd.idx[IDX_W-1:0]] <= 1'b1;
		end else if (upd.clr) begin
			used_q[upd.idx[IDX_W-1:0]] <= 1'b0;
		end
	end

	// caller guarantees query_idx is in range before trusting this
	assign query_used = used_q[query_idx[IDX_W-1:0]];

	// priority encode, lowest index wins
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

endmodule

// ===== rtl/tagged_handle_table.sv =====
// Tagged handle table top level: command intake, result stage, output register.
// Depends on htt_pkg, htt_tag_mem, htt_slot_map.
//
//  channel | valid     | stall     | word fields
//  --------+-----------+-----------+------------------------------
//  command | cmd_valid | cmd_stall | cmd, handle_in, random_tag
//  result  | rsp_valid | rsp_stall | status, handle_out, slot
//
// Accepting a command issues the tag memory read and picks the lowest free
// slot; the result stage then, once the result register can take a word,
// compares the tag, updates the slot flags and memory, and loads the result
// register. No new command is taken while the result stage holds one.
// Reset frees every slot at once; tags are not cleared.
// A stalled result holds the result stage, which in turn stalls commands.
module tagged_handle_table import htt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [1:0]          cmd,
	input  logic [HANDLE_W-1:0] handle_in,
	input  logic [TAG_W-1:0]    random_tag,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [SLOT_W-1:0]   slot
);

	localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

	logic              cmd_fire;
	logic              s1_go;
	logic              s1_valid_q;
	logic [1:0]        cmd_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              in_range_s1;
	logic              found_s1;

	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic              query_used;
	logic [TAG_W-1:0]  rd_tag;
	logic              in_range;
	logic              hit;
	slot_upd_t         upd;

	status_t             res_status;
	logic [HANDLE_W-1:0] res_handle;
	logic [SLOT_W-1:0]   res_slot;

	logic                rsp_valid_q;
	logic [1:0]          status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SLOT_W-1:0]   slot_q;

	assign cmd_stall = s1_valid_q;
	assign cmd_fire  = cmd_valid && !s1_valid_q;
	assign s1_go     = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign in_range  = {1'b0, handle_in[SLOT_W-1:0]} < (SLOT_W + 1)'(NUM_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_s1      <= cmd;
			in_range_s1 <= in_range;
			found_s1    <= free_found;
			if (cmd_t'(cmd) == CMD_CREATE) begin
				tag_s1 <= random_tag;
				idx_s1 <= free_idx;
			end else begin
				tag_s1 <= handle_in[HANDLE_W-1:SLOT_W];
				idx_s1 <= handle_in[SLOT_W-1:0];
			end
		end
	end

	htt_slot_map #(.NUM_SLOTS(NUM_SLOTS)) u_slot_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.query_idx  (idx_s1),
		.query_used (query_used),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	htt_tag_mem #(.NUM_SLOTS(NUM_SLOTS)) u_tag_mem (
		.clk     (clk),
		.wr_en   (upd.set),
		.wr_addr (idx_s1[IDX_W-1:0]),
		.wr_data (tag_s1),
		.rd_en   (cmd_fire),
		.rd_addr (handle_in[IDX_W-1:0]),
		.rd_data (rd_tag)
	);

	assign hit = in_range_s1 && query_used && (rd_tag == tag_s1);

	always_comb begin
		res_status = ST_BAD;
		res_handle = '0;
		res_slot   = '0;
		upd.set    = 1'b0;
		upd.clr    = 1'b0;
		upd.idx    = idx_s1;
		unique case (cmd_t'(cmd_s1))
			CMD_CREATE: begin
				if (found_s1) begin
					res_status = ST_OK;
					res_handle = {tag_s1, idx_s1};
					res_slot   = idx_s1;
					upd.set    = s1_go;
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_LOOKUP: begin
				if (hit) begin
					res_status = ST_OK;
					res_slot   = idx_s1;
				end
			end
			CMD_DELETE: begin
				if (hit) begin
					res_status = ST_OK;
					res_slot   = idx_s1;
					upd.clr    = s1_go;
				end
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			status_q <= res_status;
			handle_q <= res_handle;
			slot_q   <= res_slot;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign handle_out = handle_q;
	assign slot       = slot_q;

	// a command in the result stage is never dropped
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_go |=> s1_valid_q)
		else $error("result stage lost a command");

	a_upd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(upd.set && upd.clr))
		else $error("slot set and cleared together");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q != ST_OK) |-> (handle_q == '0) && (slot_q == '0))
		else $error("failed result carries nonzero handle or slot");

	a_handle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q == ST_OK) && (handle_q != '0)
		|-> handle_q[SLOT_W-1:0] == slot_q)
		else $error("created handle disagrees with slot");

endmodule

// ===== verif/tb_tagged_handle_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tagged_handle_table: directed and random command words.
// Depends on htt_pkg and the tagged_handle_table RTL; nothing else.
module tb_tagged_handle_table;
	import htt_pkg::*;

	localparam int NUM_SLOTS = NUM_SLOTS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_WORDS = 360;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic [SLOT_W-1:0]     slot;
	} table_result_t;

	// Tracks slot occupancy and tags, predicts one result per command word.
	class handle_table_checker;
		logic                slot_used    [NUM_SLOTS];
		logic                slot_written [NUM_SLOTS];
		logic [TAG_W-1:0]    slot_tag     [NUM_SLOTS];
		table_result_t       pending_results [$];
		int                  errors;
		int                  commands_seen;
		int                  results_seen;
		int                  status_count [4];

		function new();
			foreach (slot_used[i]) begin
				slot_used[i]    = 1'b0;
				slot_written[i] = 1'b0;
				slot_tag[i]     = '0;
			end
			foreach (status_count[i])
				status_count[i] = 0;
			errors = 0;
			commands_seen = 0;
			results_seen = 0;
		endfunction

		function void flag_error(string msg);
			if (errors < 10)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endfunction

		function void note_command(logic [1:0] op, logic [HANDLE_W-1:0] h,
				logic [TAG_W-1:0] tag);
			table_result_t r;
			int idx;
			r.status = ST_BAD;
			r.handle = '0;
			r.slot   = '0;
			if (op == CMD_CREATE) begin
				r.status = ST_FULL;
				for (idx = 0; idx < NUM_SLOTS; idx++) begin
					if (!slot_used[idx]) begin
						slot_used[idx]    = 1'b1;
						slot_written[idx] = 1'b1;
						slot_tag[idx]     = tag;
						r.status = ST_OK;
						r.slot   = SLOT_W'(idx);
						r.handle = {tag, SLOT_W'(idx)};
						break;
					end
				end
			end else if (op == CMD_LOOKUP || op == CMD_DELETE) begin
				idx = h[SLOT_W-1:0];
				if (idx < NUM_SLOTS && slot_used[idx] &&
						slot_tag[idx] == h[HANDLE_W-1:SLOT_W]) begin
					if (op == CMD_DELETE)
						slot_used[idx] = 1'b0;
					r.status = ST_OK;
					r.slot   = SLOT_W'(idx);
				end
			end
			status_count[r.status]++;
			commands_seen++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [HANDLE_W-1:0] h,
				logic [SLOT_W-1:0] s);
			table_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected word status %0d handle %h slot %0d",
					st, h, s));
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status)
				flag_error($sformatf("status exp %0d got %0d", want.status, st));
			if (h !== want.handle)
				flag_error($sformatf("handle_out exp %h got %h", want.handle, h));
			if (s !== want.slot)
				flag_error($sformatf("slot exp %0d got %0d", want.slot, s));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_stall;
	logic [1:0]          cmd;
	logic [HANDLE_W-1:0] handle_in;
	logic [TAG_W-1:0]    random_tag;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] handle_out;
	logic [SLOT_W-1:0]   slot;

	handle_table_checker tracker;
	int idle_pct;
	int stall_pct;
	int idle_cycles;

	tagged_handle_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.handle_in(handle_in),
		.random_tag(random_tag),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.handle_out(handle_out),
		.slot(slot)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_result(status, handle_out, slot);
	end

	// counts cycles where neither channel moves a word
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Keeps a never-written slot from being addressed: such an index is pushed out of range.
	function automatic logic [HANDLE_W-1:0] safe_handle(logic [HANDLE_W-1:0] h);
		if (h[SLOT_W-1:0] < NUM_SLOTS && !tracker.slot_written[h[SLOT_W-1:0]])
			h[SLOT_W-1:0] = h[SLOT_W-1:0] | SLOT_W'(NUM_SLOTS);
		return h;
	endfunction

	task automatic send_command(input logic [1:0] op, input logic [HANDLE_W-1:0] h,
			input logic [TAG_W-1:0] tag);
		while ($urandom_range(0, 99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid  <= 1'b1;
		cmd        <= op;
		handle_in  <= h;
		random_tag <= tag;
		do
			@(posedge clk);
		while (!(cmd_valid && !cmd_stall));
		tracker.note_command(op, h, tag);
	endtask

	task automatic random_command(output logic [1:0] op, output logic [HANDLE_W-1:0] h,
			output logic [TAG_W-1:0] tag);
		int live [$];
		int stale [$];
		int i;
		int idx;
		int roll;
		int create_pct;
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (tracker.slot_used[i])
				live.push_back(i);
			else if (tracker.slot_written[i])
				stale.push_back(i);
		end
		tag  = TAG_W'($urandom());
		h    = safe_handle($urandom());
		op   = CMD_CREATE;
		roll = $urandom_range(0, 99);
		// back off creates near full so the table keeps filling and draining
		create_pct = (live.size() >= NUM_SLOTS - 2) ? 15 : 35;
		if (roll < create_pct) begin
			op = CMD_CREATE;
		end else if (roll < 85 && live.size() > 0) begin
			idx = live[$urandom_range(0, live.size() - 1)];
			op  = (roll < 60) ? CMD_LOOKUP : CMD_DELETE;
			h   = {tracker.slot_tag[idx], SLOT_W'(idx)};
			if (roll >= 78)
				h[SLOT_W + $urandom_range(0, TAG_W - 1)] ^= 1'b1;
		end else if (roll < 92 && stale.size() > 0) begin
			// handle of a freed slot: tag still stored but must not match
			idx = stale[$urandom_range(0, stale.size() - 1)];
			op  = $urandom_range(0, 1) ? CMD_LOOKUP : CMD_DELETE;
			h   = {tracker.slot_tag[idx], SLOT_W'(idx)};
		end else if (roll < 97) begin
			op = $urandom_range(0, 1) ? CMD_LOOKUP : CMD_DELETE;
		end else begin
			op = CMD_UNUSED;
		end
	endtask

	initial begin
		logic [1:0]          op;
		logic [HANDLE_W-1:0] h;
		logic [TAG_W-1:0]    tag;
		int                  phase;
		int                  n;
		int                  phase_idle [5];
		int                  phase_stall [5];

		phase_idle  = '{0, 67, 0, 32, 0};
		phase_stall = '{0, 0, 67, 32, 0};
		tracker     = new();
		idle_pct    = 0;
		stall_pct   = 0;
		arst_n     <= 1'b0;
		cmd_valid  <= 1'b0;
		cmd        <= CMD_CREATE;
		handle_in  <= '0;
		random_tag <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unused code, fill, full, bad handles, delete and reuse
		send_command(CMD_LOOKUP, {24'hABCDEF, 8'h20}, 24'h123456);
		send_command(CMD_UNUSED, 32'hFFFF_FFFF, 24'hFFFFFF);
		send_command(CMD_CREATE, 32'hFFFF_FFFF, 24'h000000);
		send_command(CMD_CREATE, 32'h0000_00FF, 24'hFFFFFF);
		for (n = 2; n < NUM_SLOTS; n++)
			send_command(CMD_CREATE, 32'hFFFF_FF80, TAG_W'($urandom()));
		send_command(CMD_CREATE, 32'hFFFF_FFFF, 24'hA5A5A5);
		send_command(CMD_LOOKUP, {24'hFFFFFF, 8'd1}, 24'h000000);
		send_command(CMD_LOOKUP, {24'hFFFFFE, 8'd1}, 24'hFFFFFF);
		send_command(CMD_LOOKUP, 32'hFFFF_FF10, 24'h000000);
		send_command(CMD_DELETE, {24'hFFFFFF, 8'd1}, 24'h000000);
		send_command(CMD_DELETE, {24'hFFFFFF, 8'd1}, 24'h000000);
		send_command(CMD_CREATE, 32'hFFFF_FFFF, 24'h5A5A5A);
		send_command(CMD_DELETE, {24'h000000, 8'd0}, 24'hFFFFFF);

		for (phase = 0; phase < 5; phase++) begin
			idle_pct  = phase_idle[phase];
			stall_pct = phase_stall[phase];
			for (n = 0; n < PHASE_WORDS; n++) begin
				random_command(op, h, tag);
				send_command(op, h, tag);
			end
		end
		cmd_valid <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.pending_results.size() != 0)
			tracker.flag_error("results still outstanding at end of run");
		$display("Ran %0d command words over five idle/stall mixes, checked %0d results.",
			tracker.commands_seen, tracker.results_seen);
		$display("Outcomes: %0d ok, %0d table full, %0d rejected; %0d mismatches.",
			tracker.status_count[ST_OK], tracker.status_count[ST_FULL],
			tracker.status_count[ST_BAD], tracker.errors);
		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
